// ===== hw/rtl/llc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU lookup cache package
// Shared widths, reset values and the entry word layout of the cache.
// ----------------------------------------------------------------------------
package llc_pkg;

  localparam int unsigned CAP_W = 4;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd4;

  // Depth of the request queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // One word of the entry RAM
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             found;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

// ===== hw/rtl/llc_ram.sv =====
// ----------------------------------------------------------------------------
// LRU lookup cache RAM
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
module llc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/llc_queue.sv =====
// ----------------------------------------------------------------------------
// LRU lookup cache request queue
// Short FIFO that decouples classification from the entry RAM access.
// ----------------------------------------------------------------------------
module llc_queue
  import llc_pkg::*;
#(
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  item_t         slots_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slots_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/llc_front.sv =====
// ----------------------------------------------------------------------------
// LRU lookup cache front end
// Key match, victim and free slot selection, recency and occupancy update.
// ----------------------------------------------------------------------------
module llc_front
  import llc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter type         req_t       = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_cap_i,
  input  logic             accept_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [VAL_W-1:0] fill_value_i,
  input  logic             fill_found_i,
  output req_t             req_o
);

  localparam int unsigned SW = $clog2(MAX_ENTRIES);
  localparam int unsigned OW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = (OW > CAP_W) ? OW : CAP_W;

  logic [KEY_W-1:0]       key_q [MAX_ENTRIES];
  logic [SW-1:0]          rank_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [OW-1:0]          occ_q;
  logic [CAP_W-1:0]       cap_q;

  logic [MAX_ENTRIES-1:0] match, victim, inv, free_oh;
  logic [SW-1:0]          match_idx, victim_idx, free_idx, match_rank, last_rank, slot;
  logic [OW-1:0]          occ_m1;
  logic [EW-1:0]          cap_ext, max_ext, eff_cap;
  logic                   hit, occ_full, evict;

  always_comb begin
    match      = '0;
    victim     = '0;
    match_idx  = '0;
    victim_idx = '0;
    free_idx   = '0;
    match_rank = '0;
    occ_m1     = occ_q - OW'(1);
    // the least recent valid entry holds rank occupancy-1
    last_rank  = occ_m1[SW-1:0];
    inv        = ~valid_q;
    free_oh    = inv & (~inv + MAX_ENTRIES'(1));
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == key_i);
      victim[i] = valid_q[i] && (rank_q[i] == last_rank);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        match_idx  = match_idx | SW'(i);
        match_rank = match_rank | rank_q[i];
      end
      if (victim[i]) begin
        victim_idx = victim_idx | SW'(i);
      end
      if (free_oh[i]) begin
        free_idx = free_idx | SW'(i);
      end
    end
    hit     = |match;
    cap_ext = EW'(cap_q);
    max_ext = EW'(MAX_ENTRIES);
    if (cap_q == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > max_ext) begin
      eff_cap = max_ext;
    end else begin
      eff_cap = cap_ext;
    end
    occ_full = (EW'(occ_q) >= eff_cap);
    evict    = !hit && occ_full;
    priority if (hit) begin
      slot = match_idx;
    end else if (evict) begin
      slot = victim_idx;
    end else begin
      slot = free_idx;
    end
    req_o.hit        = hit;
    req_o.evict      = evict;
    req_o.slot       = slot;
    req_o.key        = key_i;
    req_o.fill_value = fill_value_i;
    req_o.fill_found = fill_found_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      cap_q   <= CAP_RESET;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_cap_i;
      end
      if (accept_i) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (hit) begin
            // promote the hit entry, age the ones that were more recent
            if (match[i]) begin
              rank_q[i] <= '0;
            end else if (valid_q[i] && (rank_q[i] < match_rank)) begin
              rank_q[i] <= rank_q[i] + SW'(1);
            end
          end else if (SW'(i) == slot) begin
            valid_q[i] <= 1'b1;
            rank_q[i]  <= '0;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + SW'(1);
          end
        end
        if (!hit && !evict) begin
          occ_q <= occ_q + OW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !hit) begin
      key_q[slot] <= key_i;
    end
  end

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key matches more than one valid entry");

  a_occ_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OW'($countones(valid_q)))
    else $error("occupancy differs from number of valid entries");

  a_single_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && evict) |-> $onehot(victim))
    else $error("eviction without exactly one least recent entry");

endmodule

// ===== hw/rtl/llc_back.sv =====
// ----------------------------------------------------------------------------
// LRU lookup cache back end
// Entry RAM access, fill write, result register and saturating counters.
// ----------------------------------------------------------------------------
module llc_back
  import llc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter type         req_t       = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  req_t             q_item_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             hit_o,
  output logic [VAL_W-1:0] value_out_o,
  output logic             found_out_o,
  output logic             evicted_o,
  output logic [KEY_W-1:0] evicted_key_o,
  output logic [CNT_W-1:0] hits_total_o,
  output logic [CNT_W-1:0] misses_total_o,
  output logic [CNT_W-1:0] evictions_total_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             state_q, state_d;
  req_t             work_q;
  logic             out_valid_q, out_valid_d;
  logic             hit_q, found_q, evicted_q;
  logic [VAL_W-1:0] value_q;
  logic [KEY_W-1:0] evkey_q;
  logic [CNT_W-1:0] hits_q, misses_q, evicts_q;

  logic             start, finish;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rd, wr;
  logic             res_found;
  logic [VAL_W-1:0] res_value;
  logic [KEY_W-1:0] res_evkey;

  // start only when the result register is free by the time the read returns
  assign start   = (state_q == ST_IDLE) && !q_empty_i && (!out_valid_q || pop_i);
  assign finish  = (state_q == ST_READ);
  assign q_pop_o = start;
  assign rd      = entry_t'(ram_rdata);

  always_comb begin
    wr.key   = work_q.key;
    wr.found = work_q.fill_found;
    wr.value = work_q.fill_value;
  end

  llc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (finish && !work_q.hit),
    .waddr_i (work_q.slot),
    .wdata_i (wr),
    .re_i    (start),
    .raddr_i (q_item_i.slot),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (work_q.hit) begin
      res_found = rd.found;
      res_value = rd.found ? rd.value : '0;
      res_evkey = '0;
    end else begin
      res_found = work_q.fill_found;
      res_value = work_q.fill_found ? work_q.fill_value : '0;
      res_evkey = work_q.evict ? rd.key : '0;
    end
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = start ? ST_READ : ST_IDLE;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        if (work_q.hit) begin
          hits_q <= (&hits_q) ? hits_q : hits_q + CNT_W'(1);
        end else begin
          misses_q <= (&misses_q) ? misses_q : misses_q + CNT_W'(1);
        end
        if (!work_q.hit && work_q.evict) begin
          evicts_q <= (&evicts_q) ? evicts_q : evicts_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      work_q <= q_item_i;
    end
    if (finish) begin
      hit_q     <= work_q.hit;
      found_q   <= res_found;
      value_q   <= res_value;
      evicted_q <= !work_q.hit && work_q.evict;
      evkey_q   <= res_evkey;
    end
  end

  // counters only move on finish, so they match the held result
  assign empty_o           = !out_valid_q;
  assign hit_o             = hit_q;
  assign value_out_o       = value_q;
  assign found_out_o       = found_q;
  assign evicted_o         = evicted_q;
  assign evicted_key_o     = evkey_q;
  assign hits_total_o      = hits_q;
  assign misses_total_o    = misses_q;
  assign evictions_total_o = evicts_q;

  a_read_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !out_valid_q)
    else $error("result register busy when read data returns");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_READ))
    else $error("result appeared without a finished RAM access");

endmodule

// ===== hw/rtl/lru_lookup_cache.sv =====
// ----------------------------------------------------------------------------
// LRU lookup cache
// Fully associative memo cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request carries a key plus the answer the backing store would give
// for it. A key already cached returns the stored value and found flag and
// becomes most recent; an unknown key stores the fill answer as most recent,
// first evicting the least recent entry (and reporting its key) once
// occupancy has reached the capacity register (zero reads as one, values
// above MAX_ENTRIES read as MAX_ENTRIES; lowering it never flushes). Value
// out is zero whenever the found flag is zero. Hit, miss and eviction totals
// saturate at all ones and are reported as they stand after the request.
// Push a request while full is low; pop a result while empty is low. The
// front end classifies one request per clock while full is low, against
// key, valid and recency registers, and queues it; the back end handles
// one request at a time on the entry RAM (registered read, then fill write
// on a miss). A result passes the queue, the RAM read and the result
// register before empty goes low. Capacity is written through the cfg
// channel, which is always ready; write it only while the cache is idle.
// Entry storage comes up unwritten and needs no clearing pass.
// ----------------------------------------------------------------------------
module lru_lookup_cache
  import llc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CAP_W-1:0]        cfg_data_i,
  input  logic                    push,
  output logic                    full,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic [VAL_W-1:0]        fill_value_i,
  input  logic                    fill_found_i,
  input  logic                    pop,
  output logic                    empty,
  output logic                    hit_o,
  output logic [VAL_W-1:0]        value_out_o,
  output logic                    found_out_o,
  output logic                    evicted_o,
  output logic signed [KEY_W-1:0] evicted_key_o,
  output logic [CNT_W-1:0]        hits_total_o,
  output logic [CNT_W-1:0]        misses_total_o,
  output logic [CNT_W-1:0]        evictions_total_o
);

  localparam int unsigned SW = $clog2(MAX_ENTRIES);

  // Classified request handed from front to back end
  typedef struct packed {
    logic             hit;
    logic             evict;
    logic [SW-1:0]    slot;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] fill_value;
    logic             fill_found;
  } req_t;

  req_t             front_req, queue_head;
  logic             accept;
  logic             q_empty, q_pop;
  logic [KEY_W-1:0] evkey;

  // capacity writes are always taken and registered in the front end
  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  llc_front #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .req_t       (req_t)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_cap_i    (cfg_data_i),
    .accept_i     (accept),
    .key_i        ($unsigned(key_i)),
    .fill_value_i (fill_value_i),
    .fill_found_i (fill_found_i),
    .req_o        (front_req)
  );

  llc_queue #(
    .item_t (req_t)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_req),
    .full_o  (full),
    .pop_i   (q_pop),
    .item_o  (queue_head),
    .empty_o (q_empty)
  );

  llc_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .req_t       (req_t)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_item_i          (queue_head),
    .q_pop_o           (q_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .hit_o             (hit_o),
    .value_out_o       (value_out_o),
    .found_out_o       (found_out_o),
    .evicted_o         (evicted_o),
    .evicted_key_o     (evkey),
    .hits_total_o      (hits_total_o),
    .misses_total_o    (misses_total_o),
    .evictions_total_o (evictions_total_o)
  );

  assign evicted_key_o = $signed(evkey);

endmodule

// ===== sim/lru_cache_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU lookup cache checker
// Watches the capacity, request and result channels of the cache, keeps a
// shadow copy of its entries and recency order, and compares every result.
// ----------------------------------------------------------------------------
module lru_cache_checker
  import llc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CAP_W-1:0]  cfg_data_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [VAL_W-1:0]  fill_value_i,
  input  logic              fill_found_i,
  input  logic              pop_i,
  input  logic              empty_i,
  input  logic              hit_i,
  input  logic [VAL_W-1:0]  value_out_i,
  input  logic              found_out_i,
  input  logic              evicted_i,
  input  logic [KEY_W-1:0]  evicted_key_i,
  input  logic [CNT_W-1:0]  hits_total_i,
  input  logic [CNT_W-1:0]  misses_total_i,
  input  logic [CNT_W-1:0]  evictions_total_i,
  output int unsigned       pending_o,
  output int unsigned       errors_o,
  output int unsigned       results_o,
  output int unsigned       hits_o,
  output int unsigned       evictions_o
);

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
    logic             found;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } lookup_t;

  // Shadow of the cache contents
  logic [KEY_W-1:0] slot_key   [MAX_ENTRIES];
  logic [VAL_W-1:0] slot_value [MAX_ENTRIES];
  logic             slot_found [MAX_ENTRIES];
  logic             slot_valid [MAX_ENTRIES];
  int unsigned      slot_rank  [MAX_ENTRIES];
  int unsigned      fill_level;
  logic [CAP_W-1:0] capacity_reg;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] evict_total;

  lookup_t     answers_q [$];
  lookup_t     want;
  int unsigned error_count;
  int unsigned result_count;
  int unsigned hit_seen;
  int unsigned evict_seen;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Look one key up in the shadow and update it the way the cache must.
  function automatic lookup_t predict_lookup(logic [KEY_W-1:0] key,
                                             logic [VAL_W-1:0] fval,
                                             logic ffound);
    lookup_t     r;
    int          match;
    int          victim;
    int unsigned lim;
    int unsigned old_rank;
    r      = '0;
    match  = -1;
    victim = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match < 0 && slot_valid[i] && slot_key[i] == key) match = i;
    end
    if (match >= 0) begin
      old_rank = slot_rank[match];
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_valid[i] && slot_rank[i] < old_rank) slot_rank[i]++;
      end
      slot_rank[match] = 0;
      r.hit   = 1'b1;
      r.found = slot_found[match];
      r.value = r.found ? slot_value[match] : '0;
      hit_total = sat_inc(hit_total);
    end else begin
      // Zero reads as one, anything above the store size as the store size
      lim = (capacity_reg == 0) ? 1 :
            (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : 32'(capacity_reg);
      if (fill_level >= lim) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
        end
      end
      if (victim >= 0) begin
        r.evicted     = 1'b1;
        r.evicted_key = slot_key[victim];
        slot_valid[victim] = 1'b0;
        evict_total = sat_inc(evict_total);
      end else begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (victim < 0 && !slot_valid[i]) victim = i;
        end
        if (victim >= 0) fill_level++;
      end
      if (victim >= 0) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_valid[i]) slot_rank[i]++;
        end
        slot_key[victim]   = key;
        slot_value[victim] = fval;
        slot_found[victim] = ffound;
        slot_valid[victim] = 1'b1;
        slot_rank[victim]  = 0;
      end
      r.found = ffound;
      r.value = ffound ? fval : '0;
      miss_total = sat_inc(miss_total);
    end
    r.hits      = hit_total;
    r.misses    = miss_total;
    r.evictions = evict_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
      error_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid   = '{default: 1'b0};
      slot_rank    = '{default: 0};
      fill_level   = 0;
      capacity_reg = CAP_RESET;
      hit_total    = '0;
      miss_total   = '0;
      evict_total  = '0;
      answers_q.delete();
      error_count  = 0;
      result_count = 0;
      hit_seen     = 0;
      evict_seen   = 0;
      pending_o   <= 0;
      errors_o    <= 0;
      results_o   <= 0;
      hits_o      <= 0;
      evictions_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity_reg = cfg_data_i;
      // Retire before predicting so a result can never match a request
      // taken at the same edge
      if (pop_i && !empty_i) begin
        result_count++;
        if (answers_q.size() == 0) begin
          $display("%0t ns: result popped with no request pending", $time);
          error_count++;
        end else begin
          want = answers_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit_i));
          check_field("value_out", want.value, value_out_i);
          check_field("found_out", 32'(want.found), 32'(found_out_i));
          check_field("evicted", 32'(want.evicted), 32'(evicted_i));
          check_field("evicted_key", want.evicted_key, evicted_key_i);
          check_field("hits_total", want.hits, hits_total_i);
          check_field("misses_total", want.misses, misses_total_i);
          check_field("evictions_total", want.evictions, evictions_total_i);
          if (want.hit) hit_seen++;
          if (want.evicted) evict_seen++;
        end
      end
      if (push_i && !full_i) begin
        answers_q.push_back(predict_lookup(key_i, fill_value_i, fill_found_i));
      end
      pending_o   <= answers_q.size();
      errors_o    <= error_count;
      results_o   <= result_count;
      hits_o      <= hit_seen;
      evictions_o <= evict_seen;
    end
  end

endmodule

// ===== sim/lru_lookup_cache_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU lookup cache testbench
// Runs a short directed sequence at the reset capacity, then random lookup
// streams over a series of capacity settings, with bursty stalls on both
// the request and the result side. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module lru_lookup_cache_test;
  import llc_pkg::*;

  localparam int unsigned MAX_ENTRIES     = 8;
  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned ITEMS_PER_PHASE = 165;
  // Margin after the last result is out before idle writes
  localparam int unsigned SETTLE_CYCLES   = 8;
  // Limit on consecutive cycles with no handshake on any channel
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  localparam logic [KEY_W-1:0] KEY_MOST_NEG = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MOST_POS = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_ZERO     = 32'h0000_0000;
  localparam logic [KEY_W-1:0] KEY_ALL_ONES = 32'hFFFF_FFFF;

  // Capacity per random phase: 8 then 2 lowers it below the occupancy,
  // 0 and 15 exercise the clamping at both ends
  localparam logic [CAP_W-1:0] PHASE_CAP [NUM_PHASES] =
    '{4'd8, 4'd2, 4'd0, 4'd15, 4'd1, 4'd3, 4'd6, 4'd5, 4'd7, 4'd4};

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CAP_W-1:0]        cfg_data_i;
  logic                    push;
  logic                    full;
  logic signed [KEY_W-1:0] key_i;
  logic [VAL_W-1:0]        fill_value_i;
  logic                    fill_found_i;
  logic                    pop = 1'b0;
  logic                    empty;
  logic                    hit_o;
  logic [VAL_W-1:0]        value_out_o;
  logic                    found_out_o;
  logic                    evicted_o;
  logic signed [KEY_W-1:0] evicted_key_o;
  logic [CNT_W-1:0]        hits_total_o;
  logic [CNT_W-1:0]        misses_total_o;
  logic [CNT_W-1:0]        evictions_total_o;

  int unsigned pending_results;
  int unsigned check_errors;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned evictions_seen;

  logic        tx_stall_on;
  logic        rx_stall_on = 1'b1;
  int unsigned rx_hold;
  int unsigned quiet_cycles = 0;
  int unsigned requests_sent;

  always #10 clk_i = ~clk_i;

  lru_lookup_cache #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .key_i            (key_i),
    .fill_value_i     (fill_value_i),
    .fill_found_i     (fill_found_i),
    .pop              (pop),
    .empty            (empty),
    .hit_o            (hit_o),
    .value_out_o      (value_out_o),
    .found_out_o      (found_out_o),
    .evicted_o        (evicted_o),
    .evicted_key_o    (evicted_key_o),
    .hits_total_o     (hits_total_o),
    .misses_total_o   (misses_total_o),
    .evictions_total_o(evictions_total_o)
  );

  lru_cache_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .push_i           (push),
    .full_i           (full),
    .key_i            (key_i),
    .fill_value_i     (fill_value_i),
    .fill_found_i     (fill_found_i),
    .pop_i            (pop),
    .empty_i          (empty),
    .hit_i            (hit_o),
    .value_out_i      (value_out_o),
    .found_out_i      (found_out_o),
    .evicted_i        (evicted_o),
    .evicted_key_i    (evicted_key_o),
    .hits_total_i     (hits_total_o),
    .misses_total_i   (misses_total_o),
    .evictions_total_i(evictions_total_o),
    .pending_o        (pending_results),
    .errors_o         (check_errors),
    .results_o        (results_seen),
    .hits_o           (hits_seen),
    .evictions_o      (evictions_seen)
  );

  // Result side: pop by default, drop pop for random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop     <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      pop     <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_stall_on && $urandom_range(0, 7) == 0) begin
      pop     <= 1'b0;
      rx_hold <= $urandom_range(0, 11);
    end else begin
      pop <= 1'b1;
    end
  end

  // Count cycles in which no handshake completes on any channel
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t ns: nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Present one request and hold it until the cache takes it; then maybe
  // leave a random gap before the next one.
  task automatic send_request(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] fval,
                              input logic ffound);
    push         <= 1'b1;
    key_i        <= key;
    fill_value_i <= fval;
    fill_found_i <= ffound;
    do @(posedge clk_i); while (full);
    requests_sent++;
    if (tx_stall_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Hold off new requests until every expected result is out, then give
  // the back end time to finish any fill write.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] key_pool [MAX_ENTRIES + 3];
    logic [KEY_W-1:0] pick;
    int unsigned      pool_size;
    int unsigned      sel;

    requests_sent = 0;
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    push         <= 1'b0;
    key_i        <= '0;
    fill_value_i <= '0;
    fill_found_i <= 1'b0;
    tx_stall_on  <= 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset capacity of four: key and value extremes,
    // a stored found flag of zero, hits that must ignore the fill answer,
    // evictions of the least recent entry and repeated hits on the newest.
    send_request(KEY_MOST_NEG, 32'hFFFF_FFFF, 1'b1);
    send_request(KEY_MOST_POS, 32'h0000_0000, 1'b1);
    send_request(KEY_ZERO, 32'hA5A5_5A5A, 1'b0);
    send_request(KEY_ALL_ONES, 32'h5A5A_A5A5, 1'b1);
    send_request(KEY_ZERO, 32'hFFFF_FFFF, 1'b1);
    send_request(KEY_MOST_NEG, 32'h0000_0000, 1'b0);
    send_request(32'h0000_0001, 32'h0000_0001, 1'b1);
    send_request(KEY_MOST_POS, 32'h8000_0000, 1'b1);
    send_request(KEY_ALL_ONES, 32'h7FFF_FFFF, 1'b0);
    send_request(32'h0000_0001, 32'h1234_5678, 1'b0);
    send_request(KEY_ALL_ONES, 32'h0000_0000, 1'b1);
    send_request(KEY_ALL_ONES, 32'hFFFF_FFFF, 1'b1);
    send_request(KEY_MOST_NEG, 32'hDEAD_BEEF, 1'b1);
    send_request(KEY_ZERO, 32'h0F0F_0F0F, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(PHASE_CAP[p]);
      // Every fourth phase and the last one run without stalls
      tx_stall_on <= !(p % 4 == 3 || p == NUM_PHASES - 1);
      rx_stall_on <= !(p % 4 == 3 || p == NUM_PHASES - 1);
      // Keep a working set a little larger than the capacity so both hits
      // and evictions stay frequent
      pool_size = (PHASE_CAP[p] == 0) ? 1 :
                  (PHASE_CAP[p] > MAX_ENTRIES) ? MAX_ENTRIES : 32'(PHASE_CAP[p]);
      pool_size += 3;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
          pick = key_pool[$urandom_range(0, pool_size - 1)];
        end else if (sel < 90) begin
          case ($urandom_range(0, 3))
            0:       pick = KEY_MOST_NEG;
            1:       pick = KEY_MOST_POS;
            2:       pick = KEY_ZERO;
            default: pick = KEY_ALL_ONES;
          endcase
        end else begin
          pick = $urandom;
        end
        send_request(pick, $urandom, 1'($urandom_range(0, 1)));
        // Now and then drain the cache completely in mid-stream
        if (tx_stall_on && $urandom_range(0, 79) == 0) wait_idle();
      end
    end

    wait_idle();
    if (pending_results != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_results);
    end
    $display("Sent %0d lookups over %0d capacity settings with stalls on both sides.",
             requests_sent, NUM_PHASES + 1);
    $display("Checked %0d results, %0d of them hits and %0d with an eviction.",
             results_seen, hits_seen, evictions_seen);
    if (check_errors == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
